// ===== rtl/qap_pkg.sv =====
// ----------------------------------------------------------------------------
// qap_pkg
// Shared widths, constants, tables and types of the quaternion attitude PID.
// ----------------------------------------------------------------------------
package qap_pkg;

	// Field and datapath widths.
	localparam int QW  = 16;   // quaternion component and time step
	localparam int CW  = 20;   // rounded error quaternion component
	localparam int PW  = 2*CW; // product of two components
	localparam int AW  = 44;   // angle arguments in Q28
	localparam int SW  = 30;   // clamped asin argument in Q28
	localparam int GW  = 48;   // gain register
	localparam int EW  = 16;   // angle error in Q3.13
	localparam int DW  = 32;   // drive value
	localparam int KW  = 47;   // CORDIC vector component
	localparam int ZW  = 28;   // CORDIC angle accumulator in Q24
	localparam int NAX = 3;

	localparam int CORDIC_ITER_DEF = 16;
	localparam int ATAN_LEN        = 24;
	localparam int QDEPTH          = 2;

	localparam logic signed [AW-1:0] ONE_Q28     = AW'(268435456);
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);

	// Axis order, which is also the register index order.
	typedef enum logic [1:0] {
		AX_ROLL  = 2'd0,
		AX_PITCH = 2'd1,
		AX_YAW   = 2'd2
	} axis_t;

	typedef logic [NAX-1:0][GW-1:0] gains_t;

	// One term of the error quaternion product: desired index, current index, sign.
	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
		logic       neg;
	} term_t;

	// Operand pair for the angle argument products (w=0, x=1, y=2, z=3).
	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
	} pair_t;

	// Work item passed from the front end to the back end.
	typedef struct packed {
		logic signed [AW-1:0] roll_y;
		logic signed [AW-1:0] roll_x;
		logic signed [SW-1:0] pitch_s;
		logic signed [AW-1:0] yaw_y;
		logic signed [AW-1:0] yaw_x;
		logic [QW-1:0]        dt;
	} arg_item_t;

	// Terms of desired * conj(current), written on the raw current components.
	function automatic term_t qp_term(input logic [3:0] k);
		term_t t;
		case (k)
			4'd0:    t = '{a: 2'd0, b: 2'd0, neg: 1'b0};
			4'd1:    t = '{a: 2'd1, b: 2'd1, neg: 1'b0};
			4'd2:    t = '{a: 2'd2, b: 2'd2, neg: 1'b0};
			4'd3:    t = '{a: 2'd3, b: 2'd3, neg: 1'b0};
			4'd4:    t = '{a: 2'd0, b: 2'd1, neg: 1'b1};
			4'd5:    t = '{a: 2'd1, b: 2'd0, neg: 1'b0};
			4'd6:    t = '{a: 2'd2, b: 2'd3, neg: 1'b1};
			4'd7:    t = '{a: 2'd3, b: 2'd2, neg: 1'b0};
			4'd8:    t = '{a: 2'd0, b: 2'd2, neg: 1'b1};
			4'd9:    t = '{a: 2'd1, b: 2'd3, neg: 1'b0};
			4'd10:   t = '{a: 2'd2, b: 2'd0, neg: 1'b0};
			4'd11:   t = '{a: 2'd3, b: 2'd1, neg: 1'b1};
			4'd12:   t = '{a: 2'd0, b: 2'd3, neg: 1'b1};
			4'd13:   t = '{a: 2'd1, b: 2'd2, neg: 1'b1};
			4'd14:   t = '{a: 2'd2, b: 2'd1, neg: 1'b0};
			4'd15:   t = '{a: 2'd3, b: 2'd0, neg: 1'b0};
			default: t = '{a: 2'd0, b: 2'd0, neg: 1'b0};
		endcase
		return t;
	endfunction

	// Products wx, yz, xx, yy, wy, zx, wz, xy, zz in that order.
	function automatic pair_t qp_pair(input logic [3:0] k);
		pair_t p;
		case (k)
			4'd0:    p = '{a: 2'd0, b: 2'd1};
			4'd1:    p = '{a: 2'd2, b: 2'd3};
			4'd2:    p = '{a: 2'd1, b: 2'd1};
			4'd3:    p = '{a: 2'd2, b: 2'd2};
			4'd4:    p = '{a: 2'd0, b: 2'd2};
			4'd5:    p = '{a: 2'd3, b: 2'd1};
			4'd6:    p = '{a: 2'd0, b: 2'd3};
			4'd7:    p = '{a: 2'd1, b: 2'd2};
			4'd8:    p = '{a: 2'd3, b: 2'd3};
			default: p = '{a: 2'd0, b: 2'd0};
		endcase
		return p;
	endfunction

	// Arctangent of 2^-i in Q24.
	function automatic logic signed [ZW-1:0] qp_atan(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:    v = ZW'(13176795);
			5'd1:    v = ZW'(7778716);
			5'd2:    v = ZW'(4110060);
			5'd3:    v = ZW'(2086331);
			5'd4:    v = ZW'(1047214);
			5'd5:    v = ZW'(524117);
			5'd6:    v = ZW'(262123);
			5'd7:    v = ZW'(131069);
			5'd8:    v = ZW'(65536);
			5'd9:    v = ZW'(32768);
			5'd10:   v = ZW'(16384);
			5'd11:   v = ZW'(8192);
			5'd12:   v = ZW'(4096);
			5'd13:   v = ZW'(2048);
			5'd14:   v = ZW'(1024);
			5'd15:   v = ZW'(512);
			5'd16:   v = ZW'(256);
			5'd17:   v = ZW'(128);
			5'd18:   v = ZW'(64);
			5'd19:   v = ZW'(32);
			5'd20:   v = ZW'(16);
			5'd21:   v = ZW'(8);
			5'd22:   v = ZW'(4);
			5'd23:   v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [DW-1:0] qp_sat32(input logic signed [53:0] v);
		logic signed [DW-1:0] r;
		if (v > 54'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -54'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/qap_front.sv =====
// ----------------------------------------------------------------------------
// qap_front
// Takes a sample, forms the error quaternion and the three angle arguments
// with one shared multiplier, and hands the arguments to the work queue.
// ----------------------------------------------------------------------------
module qap_front import qap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [9*QW-1:0]       in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output arg_item_t             out_item
);

	localparam int ACW = 35;
	localparam logic [4:0] LAST_QTERM = 5'd15;
	localparam logic [4:0] FIRST_ARG  = 5'd17;
	localparam logic [4:0] LAST_ARG   = 5'd25;
	localparam logic [4:0] FORM_STEP  = 5'd27;
	localparam logic signed [ACW-1:0] HALF_Q14 = ACW'(8192);

	logic signed [QW-1:0] des_q [4];
	logic signed [QW-1:0] cur_q [4];
	logic [QW-1:0]        dt_q;
	logic                 busy_q;
	logic                 res_vld_q;
	logic [4:0]           cnt_q;
	logic signed [PW-1:0] prod_s1;
	logic [4:0]           tag_s1;
	logic                 v_s1;
	logic signed [ACW-1:0] acc_q;
	logic signed [CW-1:0] e_q [4];
	logic signed [PW-1:0] p_q [9];
	arg_item_t            res_q;

	logic                 issue;
	term_t                t_iss;
	term_t                t_acc;
	pair_t                pr;
	logic signed [CW-1:0] op_a;
	logic signed [CW-1:0] op_b;
	logic signed [ACW-1:0] addend;
	logic signed [ACW-1:0] acc_new;
	logic signed [ACW-1:0] acc_rnd;
	logic [4:0]           arg_idx;
	logic [4:0]           st_idx;
	logic signed [AW-1:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
	logic signed [AW-1:0] s_full;
	logic signed [AW-1:0] s_clamp;
	arg_item_t            form;

	assign in_ready  = !busy_q;
	assign out_valid = res_vld_q;
	assign out_item  = res_q;

	// Operand selection for the shared multiplier.
	assign issue   = busy_q && !res_vld_q &&
		(cnt_q <= LAST_QTERM || (cnt_q >= FIRST_ARG && cnt_q <= LAST_ARG));
	assign arg_idx = cnt_q - FIRST_ARG;
	assign t_iss   = qp_term(cnt_q[3:0]);
	assign pr      = qp_pair(arg_idx[3:0]);
	always_comb begin
		if (cnt_q <= LAST_QTERM) begin
			op_a = CW'(des_q[t_iss.a]);
			op_b = CW'(cur_q[t_iss.b]);
		end else begin
			op_a = e_q[pr.a];
			op_b = e_q[pr.b];
		end
	end

	// Accumulation of the quaternion terms.
	assign t_acc   = qp_term(tag_s1[3:0]);
	assign addend  = t_acc.neg ? -ACW'(prod_s1) : ACW'(prod_s1);
	assign acc_new = (tag_s1[1:0] == 2'd0) ? addend : acc_q + addend;
	assign acc_rnd = acc_new + HALF_Q14;
	assign st_idx  = tag_s1 - FIRST_ARG;

	// Angle arguments from the stored products.
	assign wx = AW'(p_q[0]);
	assign yz = AW'(p_q[1]);
	assign xx = AW'(p_q[2]);
	assign yy = AW'(p_q[3]);
	assign wy = AW'(p_q[4]);
	assign zx = AW'(p_q[5]);
	assign wz = AW'(p_q[6]);
	assign xy = AW'(p_q[7]);
	assign zz = AW'(p_q[8]);
	assign s_full = (wy - zx) <<< 1;
	always_comb begin
		if (s_full > ONE_Q28) begin
			s_clamp = ONE_Q28;
		end else if (s_full < -ONE_Q28) begin
			s_clamp = -ONE_Q28;
		end else begin
			s_clamp = s_full;
		end
		form.roll_y  = (wx + yz) <<< 1;
		form.roll_x  = ONE_Q28 - ((xx + yy) <<< 1);
		form.pitch_s = SW'(s_clamp);
		form.yaw_y   = (wz + xy) <<< 1;
		form.yaw_x   = ONE_Q28 - ((yy + zz) <<< 1);
		form.dt      = dt_q;
	end

	// Control: sample capture, step counter and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			res_vld_q <= 1'b0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (res_vld_q) begin
				if (out_ready) begin
					res_vld_q <= 1'b0;
					busy_q    <= 1'b0;
				end
			end else if (busy_q) begin
				if (cnt_q == FORM_STEP) begin
					res_vld_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int k = 0; k < 4; k++) begin
				des_q[k] <= in_data[k*QW +: QW];
				cur_q[k] <= in_data[(k+4)*QW +: QW];
			end
			dt_q <= in_data[8*QW +: QW];
		end
		prod_s1 <= op_a * op_b;
		tag_s1  <= cnt_q;
		if (v_s1 && tag_s1 <= LAST_QTERM) begin
			acc_q <= acc_new;
			if (tag_s1[1:0] == 2'd3) begin
				e_q[tag_s1[3:2]] <= CW'(acc_rnd >>> 14);
			end
		end
		if (v_s1 && tag_s1 >= FIRST_ARG) begin
			p_q[st_idx[3:0]] <= prod_s1;
		end
		if (busy_q && !res_vld_q && cnt_q == FORM_STEP) begin
			res_q <= form;
		end
	end

endmodule

// ===== rtl/qap_queue.sv =====
// ----------------------------------------------------------------------------
// qap_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module qap_queue import qap_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QDEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [WIDTH-1:0]           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [WIDTH-1:0]           out_data,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTW-1:0]   wr_q;
	logic [PTW-1:0]   rd_q;
	logic [LVW-1:0]   cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != LVW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign level     = cnt_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTW'(DEPTH-1)) ? '0 : wr_q + PTW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTW'(DEPTH-1)) ? '0 : rd_q + PTW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + LVW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - LVW'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

// ===== rtl/qap_back.sv =====
// ----------------------------------------------------------------------------
// qap_back
// Square root for the pitch cosine, shared CORDIC for the three angles,
// and the per-axis PID with a bit-serial divider for the derivative.
// ----------------------------------------------------------------------------
module qap_back import qap_pkg::*; #(
	parameter int ITERATIONS = CORDIC_ITER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gains_t            gains,
	input  logic              in_valid,
	output logic              in_ready,
	input  arg_item_t         in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NAX*DW-1:0] out_data
);

	localparam int NIT = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;
	localparam logic [5:0] SQRT_LAST = 6'd28;
	localparam logic [5:0] DIV_LAST  = 6'd32;
	localparam logic [57:0] ONE_Q56  = 58'd1 << 56;

	typedef enum logic [10:0] {
		B_IDLE  = 11'b000_0000_0001,
		B_SQM   = 11'b000_0000_0010,
		B_SQRT  = 11'b000_0000_0100,
		B_CINIT = 11'b000_0000_1000,
		B_CRUN  = 11'b000_0001_0000,
		B_ANG   = 11'b000_0010_0000,
		B_IMUL  = 11'b000_0100_0000,
		B_DIV   = 11'b000_1000_0000,
		B_PMUL  = 11'b001_0000_0000,
		B_SUM   = 11'b010_0000_0000,
		B_DONE  = 11'b100_0000_0000
	} bstate_t;

	bstate_t              st_q;
	arg_item_t            item_q;
	logic [5:0]           cnt_q;
	axis_t                axis_q;
	logic [56:0]          sq_s1;
	logic [57:0]          rad_q;
	logic [57:0]          root_q;
	logic signed [KW-1:0] cx_q;
	logic signed [KW-1:0] cy_q;
	logic signed [ZW-1:0] cz_q;
	logic                 zero_q;
	logic signed [EW-1:0] e_q;
	logic signed [32:0]   mp_s1;
	logic signed [DW-1:0] integ_q [NAX];
	logic signed [EW-1:0] last_q [NAX];
	logic [32:0]          num_q;
	logic [16:0]          rem_q;
	logic [32:0]          quo_q;
	logic                 dneg_q;
	logic signed [51:0]   pprod_s1;
	logic signed [53:0]   pacc_q;
	logic signed [DW-1:0] drv_q [NAX];
	logic [NAX*DW-1:0]    out_q;
	logic                 out_vld_q;

	logic signed [2*SW-1:0] ps2;
	logic [57:0]          sq_n;
	logic [57:0]          sq_r;
	logic [5:0]           sq_sh;
	logic [57:0]          sq_bit;
	logic [57:0]          sq_trial;
	logic signed [KW-1:0] vy;
	logic signed [KW-1:0] vx;
	logic signed [KW-1:0] xs;
	logic signed [KW-1:0] ys;
	logic signed [ZW-1:0] z_rnd;
	logic signed [16:0]   diff;
	logic [16:0]          mag;
	logic signed [33:0]   isum;
	logic [17:0]          remsh;
	logic                 qbit;
	logic signed [33:0]   deriv;
	logic [QW-1:0]        kgain;
	logic signed [34:0]   kval;
	logic signed [53:0]   total;
	logic signed [53:0]   rnd;
	logic                 out_free;

	assign in_ready  = st_q == B_IDLE;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign out_free  = !out_vld_q || out_ready;

	// Square root step: one result bit per cycle.
	assign ps2      = item_q.pitch_s * item_q.pitch_s;
	assign sq_n     = (cnt_q == '0) ? ONE_Q56 - 58'(sq_s1) : rad_q;
	assign sq_r     = (cnt_q == '0) ? '0 : root_q;
	assign sq_sh    = 6'd56 - {cnt_q[4:0], 1'b0};
	assign sq_bit   = 58'd1 << sq_sh;
	assign sq_trial = sq_r + sq_bit;

	// Vector selection for the CORDIC by axis.
	always_comb begin
		case (axis_q)
			AX_ROLL: begin
				vy = KW'(item_q.roll_y);
				vx = KW'(item_q.roll_x);
			end
			AX_PITCH: begin
				vy = KW'(item_q.pitch_s);
				vx = $signed({{(KW-29){1'b0}}, root_q[28:0]});
			end
			AX_YAW: begin
				vy = KW'(item_q.yaw_y);
				vx = KW'(item_q.yaw_x);
			end
			default: begin
				vy = '0;
				vx = '0;
			end
		endcase
	end

	// CORDIC vectoring step.
	assign xs    = cx_q >>> cnt_q[4:0];
	assign ys    = cy_q >>> cnt_q[4:0];
	assign z_rnd = cz_q + ZW'(1024);

	// PID helpers.
	assign diff  = 17'(e_q) - 17'(last_q[axis_q]);
	assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
	assign isum  = 34'(integ_q[axis_q]) + 34'((mp_s1 + 33'sd32768) >>> 16);
	assign remsh = {rem_q, num_q[32]};
	assign qbit  = remsh >= 18'(item_q.dt);
	assign deriv = (item_q.dt == '0) ? '0 :
		(dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				kgain = gains[axis_q][47:32];
				kval  = 35'(e_q);
			end
			2'd1: begin
				kgain = gains[axis_q][31:16];
				kval  = 35'(integ_q[axis_q]);
			end
			2'd2: begin
				kgain = gains[axis_q][15:0];
				kval  = 35'(deriv);
			end
			default: begin
				kgain = '0;
				kval  = '0;
			end
		endcase
	end
	assign total = pacc_q + 54'(pprod_s1);
	assign rnd   = (total + 54'sd128) >>> 8;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			cnt_q     <= '0;
			axis_q    <= AX_ROLL;
			out_vld_q <= 1'b0;
			for (int k = 0; k < NAX; k++) begin
				integ_q[k] <= '0;
				last_q[k]  <= '0;
			end
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (st_q == B_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (in_valid) begin
						st_q <= B_SQM;
					end
				end
				B_SQM: begin
					cnt_q <= '0;
					st_q  <= B_SQRT;
				end
				B_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						axis_q <= AX_ROLL;
						st_q   <= B_CINIT;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				B_CINIT: begin
					cnt_q <= '0;
					st_q  <= B_CRUN;
				end
				B_CRUN: begin
					if (cnt_q == 6'(NIT-1)) begin
						st_q <= B_ANG;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				B_ANG: begin
					st_q <= B_IMUL;
				end
				B_IMUL: begin
					last_q[axis_q] <= e_q;
					cnt_q <= '0;
					st_q  <= B_DIV;
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						integ_q[axis_q] <= qp_sat32(54'(isum));
					end
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						st_q  <= B_PMUL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_PMUL: begin
					if (cnt_q == 6'd2) begin
						st_q <= B_SUM;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				B_SUM: begin
					if (axis_q == AX_YAW) begin
						st_q <= B_DONE;
					end else begin
						axis_q <= axis_t'(axis_q + 2'd1);
						st_q   <= B_CINIT;
					end
				end
				B_DONE: begin
					if (out_free) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (in_valid) begin
					item_q <= in_item;
				end
			end
			B_SQM: begin
				sq_s1 <= 57'(ps2);
			end
			B_SQRT: begin
				if (sq_n >= sq_trial) begin
					rad_q  <= sq_n - sq_trial;
					root_q <= (sq_r >> 1) + sq_bit;
				end else begin
					rad_q  <= sq_n;
					root_q <= sq_r >> 1;
				end
			end
			B_CINIT: begin
				zero_q <= (vx == '0) && (vy == '0);
				if (vx[KW-1]) begin
					if (!vy[KW-1]) begin
						cx_q <= vy;
						cy_q <= -vx;
						cz_q <= HALF_PI_Q24;
					end else begin
						cx_q <= -vy;
						cy_q <= vx;
						cz_q <= -HALF_PI_Q24;
					end
				end else begin
					cx_q <= vx;
					cy_q <= vy;
					cz_q <= '0;
				end
			end
			B_CRUN: begin
				if (!cy_q[KW-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + qp_atan(cnt_q[4:0]);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - qp_atan(cnt_q[4:0]);
				end
			end
			B_ANG: begin
				e_q <= zero_q ? '0 : EW'(z_rnd >>> 11);
			end
			B_IMUL: begin
				mp_s1  <= e_q * $signed({1'b0, item_q.dt});
				dneg_q <= diff[16];
				num_q  <= {mag[15:0], 16'b0, 1'b0} >> 1 | {mag[16], 32'b0};
				rem_q  <= '0;
				quo_q  <= '0;
			end
			B_DIV: begin
				rem_q <= qbit ? 17'(remsh - 18'(item_q.dt)) : 17'(remsh);
				num_q <= {num_q[31:0], 1'b0};
				quo_q <= {quo_q[31:0], qbit};
			end
			B_PMUL: begin
				pprod_s1 <= $signed({1'b0, kgain}) * kval;
				if (cnt_q == 6'd1) begin
					pacc_q <= 54'(pprod_s1);
				end else if (cnt_q == 6'd2) begin
					pacc_q <= total;
				end
			end
			B_SUM: begin
				drv_q[axis_q] <= qp_sat32(rnd);
			end
			B_DONE: begin
				if (out_free) begin
					out_q <= {drv_q[2], drv_q[1], drv_q[0]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/quaternion_attitude_pid_core.sv =====
// The back end takes no new sample until the last one has passed the 29-step
// square root, the shared CORDIC and the 33-step derivative divider in turn.
// The front end prepares the next sample while the back end works.
// Reset (arst_n low) clears the gains, integrals, previous errors and queue.
// ----------------------------------------------------------------------------
// quaternion_attitude_pid_core
// Attitude error from two quaternions, converted to roll, pitch and yaw
// errors and driven through three PID loops.
// ----------------------------------------------------------------------------
module quaternion_attitude_pid_core import qap_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF,
	parameter int QUEUE_DEPTH       = QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// desired_w, desired_x, desired_y, desired_z,
	// current_w, current_x, current_y, current_z, step_time
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [9*QW-1:0]   s_axis_tdata,
	// roll_drive, pitch_drive, yaw_drive
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [NAX*DW-1:0] m_axis_tdata,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [GW-1:0]     wr_data
);

	localparam int LVW = $clog2(QUEUE_DEPTH+1);
	localparam int IW  = $bits(arg_item_t);

	gains_t         gains_q;
	logic           fq_valid;
	logic           fq_ready;
	arg_item_t      fq_item;
	logic           bq_valid;
	logic           bq_ready;
	logic [IW-1:0]  bq_data;
	logic [LVW-1:0] q_level;

	// Gain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			case (axis_t'(wr_index))
				AX_ROLL:  gains_q[AX_ROLL]  <= wr_data;
				AX_PITCH: gains_q[AX_PITCH] <= wr_data;
				AX_YAW:   gains_q[AX_YAW]   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	qap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	qap_queue #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_item),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_data  (bq_data),
		.level     (q_level)
	);

	qap_back #(
		.ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.in_valid  (bq_valid),
		.in_ready  (bq_ready),
		.in_item   (arg_item_t'(bq_data)),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// The front end works on one sample at a time.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("front end accepted a sample while busy");

	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= LVW'(QUEUE_DEPTH))
		else $error("queue overfilled");

	// The back end takes work only from a non-empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(bq_valid && bq_ready) |-> (q_level != '0))
		else $error("back end took from an empty queue");

endmodule

// ===== dv/tb_quaternion_attitude_pid_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_attitude_pid_core
// Self-checking bench for the quaternion attitude PID core. A cycle-free
// predictor computes the three drive values of each accepted sample request,
// and a checker compares every result request against the oldest prediction.
// The sender works in random bursts, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_quaternion_attitude_pid_core;
	import qap_pkg::*;

	localparam int N_ITER   = 16;
	localparam int SETTLE   = 300;
	localparam int N_RANDOM = 1625;

	typedef struct {
		logic signed [DW-1:0] roll;
		logic signed [DW-1:0] pitch;
		logic signed [DW-1:0] yaw;
	} drives_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [9*QW-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [NAX*DW-1:0] m_axis_tdata;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [GW-1:0]     wr_data;

	// Predictor state.
	logic [GW-1:0] gain_q [NAX];
	longint        integ_q [NAX];
	longint        prev_err_q [NAX];

	drives_t expected_drives [$];
	int      error_count;
	int      burst_left;
	int      stall_left;
	bit      stall_mode;
	bit      ready_mode;

	quaternion_attitude_pid_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint round_q(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat_q31(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// Vectoring CORDIC arctangent, angle returned in Q3.13.
	function automatic longint vec_atan2(longint y, longint x);
		longint z;
		longint t;
		longint xs;
		longint ys;
		z = 0;
		if (x == 0 && y == 0) begin
			return 0;
		end
		// Left half plane: pre-rotate by a quarter turn.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(HALF_PI_Q24);
			end else begin
				x = -y;
				y = t;
				z = -longint'(HALF_PI_Q24);
			end
		end
		for (int i = 0; i < N_ITER && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(qp_atan(5'(i)));
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(qp_atan(5'(i)));
			end
		end
		return round_q(z, 11);
	endfunction

	// One PID loop; updates the integral and previous error of the axis.
	function automatic longint pid_axis(int ax, longint e, longint dt);
		longint kp;
		longint ki;
		longint kd;
		longint deriv;
		kp = longint'(gain_q[ax][47:32]);
		ki = longint'(gain_q[ax][31:16]);
		kd = longint'(gain_q[ax][15:0]);
		integ_q[ax] = sat_q31(integ_q[ax] + round_q(e * dt, 16));
		deriv = (dt != 0) ? ((e - prev_err_q[ax]) * 65536) / dt : 0;
		prev_err_q[ax] = e;
		return sat_q31(round_q(kp * e + ki * integ_q[ax] + kd * deriv, 8));
	endfunction

	function automatic drives_t predict_drives(logic [9*QW-1:0] d);
		longint dw, dx, dy, dz, cw, cx, cy, cz, dt;
		longint w, x, y, z, s, c;
		drives_t r;
		dw = longint'($signed(d[0*QW +: QW]));
		dx = longint'($signed(d[1*QW +: QW]));
		dy = longint'($signed(d[2*QW +: QW]));
		dz = longint'($signed(d[3*QW +: QW]));
		cw = longint'($signed(d[4*QW +: QW]));
		cx = -longint'($signed(d[5*QW +: QW]));
		cy = -longint'($signed(d[6*QW +: QW]));
		cz = -longint'($signed(d[7*QW +: QW]));
		dt = longint'(d[8*QW +: QW]);
		w = round_q(dw * cw - dx * cx - dy * cy - dz * cz, 14);
		x = round_q(dw * cx + dx * cw + dy * cz - dz * cy, 14);
		y = round_q(dw * cy - dx * cz + dy * cw + dz * cx, 14);
		z = round_q(dw * cz + dx * cy - dy * cx + dz * cw, 14);
		// Pitch sine is clamped before the cosine is taken.
		s = 2 * (w * y - z * x);
		if (s > 64'sd268435456) s = 64'sd268435456;
		if (s < -64'sd268435456) s = -64'sd268435456;
		c = isqrt(longint'(64'd1 << 56) - s * s);
		r.roll  = DW'(pid_axis(AX_ROLL,
			vec_atan2(2 * (w * x + y * z), 64'sd268435456 - 2 * (x * x + y * y)), dt));
		r.pitch = DW'(pid_axis(AX_PITCH, vec_atan2(s, c), dt));
		r.yaw   = DW'(pid_axis(AX_YAW,
			vec_atan2(2 * (w * z + x * y), 64'sd268435456 - 2 * (y * y + z * z)), dt));
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Result checker, sampled at the rising edge.
	always @(posedge clk) begin
		drives_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_drives.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[DW-1:0], '0);
			end else begin
				w = expected_drives.pop_front();
				if (m_axis_tdata[0*DW +: DW] !== w.roll)
					report_mismatch("roll_drive", m_axis_tdata[0*DW +: DW], w.roll);
				if (m_axis_tdata[1*DW +: DW] !== w.pitch)
					report_mismatch("pitch_drive", m_axis_tdata[1*DW +: DW], w.pitch);
				if (m_axis_tdata[2*DW +: DW] !== w.yaw)
					report_mismatch("yaw_drive", m_axis_tdata[2*DW +: DW], w.yaw);
			end
		end
	end

	// Receiver stall pattern: runs of steady ready, of stall with an occasional ready, or of random ready.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(1, 60);
			stall_mode <= $urandom_range(0, 2) == 0;
			ready_mode <= $urandom_range(0, 1);
		end else begin
			stall_left <= stall_left - 1;
		end
		m_axis_tready <= stall_mode ? 1'($urandom) : ready_mode | ($urandom_range(0, 7) == 0);
	end

	task automatic send_sample(logic [9*QW-1:0] d);
		// Random gaps between bursts of back-to-back requests.
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		expected_drives.push_back(predict_drives(d));
		@(negedge clk);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_drives.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_gains(logic [GW-1:0] roll, logic [GW-1:0] pitch, logic [GW-1:0] yaw);
		logic [GW-1:0] v [NAX];
		v = '{roll, pitch, yaw};
		for (int a = 0; a < NAX; a++) begin
			wr_en    <= 1'b1;
			wr_index <= 2'(a);
			wr_data  <= v[a];
			gain_q[a] = v[a];
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	function automatic logic [9*QW-1:0] pack_sample(logic [QW-1:0] q [8], logic [QW-1:0] dt);
		logic [9*QW-1:0] d;
		for (int k = 0; k < 8; k++) d[k*QW +: QW] = q[k];
		d[8*QW +: QW] = dt;
		return d;
	endfunction

	function automatic logic [GW-1:0] random_gains();
		return {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
			16'($urandom_range(0, 256))};
	endfunction

	// Directed corners: identity, half turns, zero vectors, clamped asin, extreme steps.
	task automatic test_directed();
		logic [QW-1:0] q [8];
		write_gains({16'h0100, 16'h0080, 16'h0010}, {16'h0200, 16'h0040, 16'h0020},
			{16'h0180, 16'h0100, 16'h0008});
		q = '{16'd16384, 0, 0, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd1));
		send_sample(pack_sample(q, 16'hFFFF));
		// Roll half turn: atan2 of zero over negative gives plus pi.
		q = '{0, 16'd16384, 0, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd655));
		q = '{0, 0, 0, 16'd16384, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd655));
		q = '{0, 16'hC000, 0, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd655));
		// Pitch near and beyond a quarter turn.
		q = '{16'd11585, 0, 16'd11585, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd100));
		q = '{16'd16384, 0, 16'd16384, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd100));
		q = '{16'd16384, 0, 16'hC000, 0, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd100));
		// All-zero quaternions give a zero error quaternion and so a zero angle on every axis.
		q = '{0, 0, 0, 0, 0, 0, 0, 0};
		send_sample(pack_sample(q, 16'd1));
		for (int k = 0; k < 8; k++) q[k] = 16'h7FFF;
		send_sample(pack_sample(q, 16'hFFFF));
		for (int k = 0; k < 8; k++) q[k] = 16'h8000;
		send_sample(pack_sample(q, 16'hFFFF));
		for (int k = 0; k < 8; k++) q[k] = k[0] ? 16'h8000 : 16'h7FFF;
		send_sample(pack_sample(q, 16'h8000));
		for (int k = 0; k < 8; k++) q[k] = k[1] ? 16'h7FFF : 16'h8000;
		send_sample(pack_sample(q, 16'd1));
		q = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
		send_sample(pack_sample(q, 16'd2));
		settle_idle();
		// Largest gains drive the integral and outputs into saturation.
		write_gains({GW{1'b1}}, {GW{1'b1}}, {GW{1'b1}});
		for (int n = 0; n < 6; n++) begin
			q = '{0, 16'd16384, 16'h8000, 16'h7FFF, 16'd16384, 0, 0, 0};
			send_sample(pack_sample(q, 16'hFFFF));
		end
		q = '{0, 16'hC000, 16'h7FFF, 16'h8000, 16'd16384, 0, 0, 0};
		send_sample(pack_sample(q, 16'd1));
		q = '{16'd16384, 0, 0, 0, 0, 16'd16384, 0, 0};
		send_sample(pack_sample(q, 16'd1));
		settle_idle();
	endtask

	// Random samples: w near one and x, y, z within a random spread, some components raw 16-bit noise.
	task automatic test_random(int count);
		logic [QW-1:0] q [8];
		int spread;
		for (int n = 0; n < count; n++) begin
			spread = ($urandom_range(0, 1) == 0) ? 3000 : 16000;
			for (int k = 0; k < 8; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					q[k] = 16'($urandom);
				end else if (k == 0 || k == 4) begin
					q[k] = 16'(16384 - $urandom_range(0, spread));
				end else begin
					q[k] = 16'($urandom_range(0, 2 * spread) - spread);
				end
			end
			send_sample(pack_sample(q, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 1000))));
		end
		settle_idle();
	endtask

	task automatic test_gain_phases();
		write_gains(random_gains(), random_gains(), random_gains());
		test_random(N_RANDOM / 5);
		write_gains(48'($urandom) << 24 | 48'($urandom), {GW{1'b1}}, 48'h0);
		test_random(N_RANDOM / 5);
		write_gains(48'h0, 48'h0, 48'h0);
		test_random(N_RANDOM / 5);
		write_gains({16'hFFFF, 32'h0}, {16'h0, 16'hFFFF, 16'h0}, {32'h0, 16'hFFFF});
		test_random(N_RANDOM / 5);
		write_gains(random_gains(), random_gains(), {GW{1'b1}});
		test_random(N_RANDOM - 4 * (N_RANDOM / 5));
	endtask

	initial begin
		error_count   = 0;
		burst_left    = 0;
		stall_left    = 0;
		stall_mode    = 1'b0;
		ready_mode    = 1'b1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		for (int a = 0; a < NAX; a++) begin
			gain_q[a]     = '0;
			integ_q[a]    = 0;
			prev_err_q[a] = 0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_gain_phases();
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit, several times the slowest correct run.
	initial begin
		#100ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== quaternion_attitude_pid_core.f =====
rtl/qap_pkg.sv
rtl/qap_front.sv
rtl/qap_queue.sv
rtl/qap_back.sv
rtl/quaternion_attitude_pid_core.sv
dv/tb_quaternion_attitude_pid_core.sv
